// File: design/dpe_pkg.sv
// ----------------------------------------------------------------------------
// dpe_pkg
// Shared types, constants and the phase ramp table of the double-pulse
// LED envelope.
// ----------------------------------------------------------------------------
package dpe_pkg;

    // field widths
    localparam int TIME_W      = 32;
    localparam int DUR_W       = 16;
    localparam int CH_W        = 8;
    localparam int CNT_W       = 8;
    localparam int COLOUR_W    = 24;
    localparam int PHASE_W     = 3;
    localparam int NUM_PHASES  = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int USER_W      = 2;

    // divider geometry: dividend is elapsed (16b) times a span (8b)
    localparam int DIV_W       = DUR_W + CH_W;
    localparam int DIV_STEPS   = DIV_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // phase codes
    typedef logic [PHASE_W-1:0] t_phase;
    localparam t_phase PH_RISE_ONE = 3'd0;
    localparam t_phase PH_FALL_ONE = 3'd1;
    localparam t_phase PH_GAP_ONE  = 3'd2;
    localparam t_phase PH_RISE_TWO = 3'd3;
    localparam t_phase PH_FALL_TWO = 3'd4;
    localparam t_phase PH_GAP_TWO  = 3'd5;

    // brightness levels
    localparam logic [CH_W-1:0] LVL_GAP      = 8'd20;
    localparam logic [CH_W-1:0] LVL_PEAK_ONE = 8'd255;
    localparam logic [CH_W-1:0] LVL_PEAK_TWO = 8'd200;

    // register reset values
    localparam logic [DUR_W-1:0]    RST_RISE_ONE = 16'd130;
    localparam logic [DUR_W-1:0]    RST_FALL_ONE = 16'd190;
    localparam logic [DUR_W-1:0]    RST_GAP_ONE  = 16'd70;
    localparam logic [DUR_W-1:0]    RST_RISE_TWO = 16'd100;
    localparam logic [DUR_W-1:0]    RST_FALL_TWO = 16'd230;
    localparam logic [DUR_W-1:0]    RST_GAP_TWO  = 16'd360;
    localparam logic [COLOUR_W-1:0] RST_COLOUR   = 24'd0;
    localparam logic [CNT_W-1:0]    RST_TOTAL    = 8'd3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RISE_ONE = 3'd0,
        CFG_FALL_ONE = 3'd1,
        CFG_GAP_ONE  = 3'd2,
        CFG_RISE_TWO = 3'd3,
        CFG_FALL_TWO = 3'd4,
        CFG_GAP_TWO  = 3'd5,
        CFG_COLOUR   = 3'd6,
        CFG_TOTAL    = 3'd7
    } t_cfg_idx;

    // colour channel select
    typedef logic [1:0] t_chan;
    localparam t_chan CH_RED   = 2'd0;
    localparam t_chan CH_GREEN = 2'd1;
    localparam t_chan CH_BLUE  = 2'd2;

    // result kind flags in tuser
    localparam logic [USER_W-1:0] USER_FRAME = 2'b01;
    localparam logic [USER_W-1:0] USER_DONE  = 2'b10;

    // configuration registers as one bundle
    typedef struct packed {
        logic [NUM_PHASES-1:0][DUR_W-1:0] dur;
        logic [COLOUR_W-1:0]              colour;
        logic [CNT_W-1:0]                 total;
    } t_cfg;

    // controller to datapath
    typedef struct packed {
        logic  load;
        logic  eval;
        logic  div_start;
        logic  scale;
        t_chan chan;
        logic  write;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic finish;
        logic div_done;
        logic out_free;
    } t_sts;

    // linear ramp of one phase: start level, span and direction
    typedef struct packed {
        logic [CH_W-1:0] from;
        logic [CH_W-1:0] span;
        logic            up;
    } t_ramp;

    function automatic t_ramp phase_ramp(input t_phase ph);
        t_ramp r;
        r.from = LVL_GAP;
        r.span = '0;
        r.up   = 1'b1;
        unique case (ph)
            PH_RISE_ONE: begin
                r.from = LVL_GAP;
                r.span = LVL_PEAK_ONE - LVL_GAP;
                r.up   = 1'b1;
            end
            PH_FALL_ONE: begin
                r.from = LVL_PEAK_ONE;
                r.span = LVL_PEAK_ONE - LVL_GAP;
                r.up   = 1'b0;
            end
            PH_RISE_TWO: begin
                r.from = LVL_GAP;
                r.span = LVL_PEAK_TWO - LVL_GAP;
                r.up   = 1'b1;
            end
            PH_FALL_TWO: begin
                r.from = LVL_PEAK_TWO;
                r.span = LVL_PEAK_TWO - LVL_GAP;
                r.up   = 1'b0;
            end
            default: begin
                r.from = LVL_GAP;
                r.span = '0;
                r.up   = 1'b1;
            end
        endcase
        return r;
    endfunction

endpackage

// File: design/dpe_div.sv
// ----------------------------------------------------------------------------
// dpe_div
// Restoring unsigned divider, one quotient bit per cycle. Returns the low
// byte of the quotient; the caller guarantees it fits.
// ----------------------------------------------------------------------------
module dpe_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dpe_pkg::DIV_W-1:0]     i_dividend,
    input  logic [dpe_pkg::DUR_W-1:0]     i_divisor,
    output logic [dpe_pkg::CH_W-1:0]      o_quo,
    output logic                          o_done
);
    import dpe_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DUR_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_quo;

    logic [DUR_W:0]       trial;
    logic [DUR_W:0]       diff;
    logic                 fits;

    // trial subtract of the shifted remainder
    always_comb begin
        trial = {r_rem, r_quo[DIV_W-1]};
        diff  = trial - {1'b0, i_divisor};
        fits  = trial >= {1'b0, i_divisor};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], fits};
        end
    end

    assign o_quo  = r_quo[CH_W-1:0];
    assign o_done = r_done;

endmodule

// File: design/dpe_dp.sv
// ----------------------------------------------------------------------------
// dpe_dp
// Datapath: phase timing state, ramp product, divider, colour scaling and
// the output register.
// ----------------------------------------------------------------------------
module dpe_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dpe_pkg::t_cfg                 i_cfg,
    input  dpe_pkg::t_cmd                 i_cmd,
    output dpe_pkg::t_sts                 o_sts,
    input  logic [dpe_pkg::TIME_W-1:0]    i_now,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [4*dpe_pkg::CH_W-1:0]    o_out_data,  // red, green, blue, level
    output logic [dpe_pkg::USER_W-1:0]    o_out_user   // frame_update, effect_done
);
    import dpe_pkg::*;

    // timing state
    logic [TIME_W-1:0] r_now;
    t_phase            r_phase;
    logic [TIME_W-1:0] r_begin;
    logic [CNT_W-1:0]  r_cycles;
    logic              r_running;
    logic              r_done;

    // per-item operands
    logic [DUR_W-1:0]  r_x;
    logic              r_zero;
    logic [DUR_W-1:0]  r_div;
    t_ramp             r_ramp;
    logic [CH_W-1:0]   r_level;
    logic [CH_W-1:0]   r_red;
    logic [CH_W-1:0]   r_green;
    logic [CH_W-1:0]   r_blue;

    // output register
    logic                  r_out_valid;
    logic [4*CH_W-1:0]     r_out_data;
    logic [USER_W-1:0]     r_out_user;

    t_phase            eff_phase;
    t_phase            next_phase;
    logic [TIME_W-1:0] eff_begin;
    logic [CNT_W-1:0]  eff_cycles;
    logic [CNT_W-1:0]  cycles_inc;
    logic [TIME_W-1:0] elapsed;
    logic [DUR_W-1:0]  dur;
    logic              advance;
    logic              wrap;
    logic              finish;

    logic [DIV_W-1:0]  product;
    logic [CH_W-1:0]   div_quo;
    logic              div_done;
    logic [CH_W-1:0]   quo;

    logic [CH_W-1:0]   chan_in;
    logic [CH_W:0]     level_inc;
    logic [2*CH_W:0]   scaled;

    // phase evaluation, restart when idle
    always_comb begin
        eff_phase  = (r_running && (r_phase <= PH_GAP_TWO)) ? r_phase : PH_RISE_ONE;
        eff_begin  = r_running ? r_begin : r_now;
        eff_cycles = r_running ? r_cycles : '0;
        elapsed    = r_now - eff_begin;
        dur        = i_cfg.dur[eff_phase];
        advance    = elapsed >= {{(TIME_W-DUR_W){1'b0}}, dur};
        wrap       = advance && (eff_phase == PH_GAP_TWO);
        cycles_inc = eff_cycles + 1'b1;
        finish     = wrap && (cycles_inc >= i_cfg.total);
        if (!advance) begin
            next_phase = eff_phase;
        end else if (wrap) begin
            next_phase = PH_RISE_ONE;
        end else begin
            next_phase = eff_phase + 1'b1;
        end
    end

    // timing state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_RISE_ONE;
            r_begin   <= '0;
            r_cycles  <= '0;
            r_running <= 1'b0;
            r_done    <= 1'b0;
        end else if (i_cmd.eval) begin
            r_done <= finish;
            if (finish) begin
                r_phase   <= PH_RISE_ONE;
                r_begin   <= '0;
                r_cycles  <= '0;
                r_running <= 1'b0;
            end else begin
                r_phase   <= next_phase;
                r_begin   <= advance ? r_now : eff_begin;
                r_cycles  <= wrap ? cycles_inc : eff_cycles;
                r_running <= 1'b1;
            end
        end
    end

    // item capture and ramp operands
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now <= i_now;
        end
        if (i_cmd.eval) begin
            r_x    <= advance ? '0 : elapsed[DUR_W-1:0];
            r_zero <= advance || (elapsed == '0);
            r_div  <= dur;
            r_ramp <= phase_ramp(next_phase);
        end
    end

    // elapsed times span, divided by the phase duration
    assign product = DIV_W'(r_x) * DIV_W'(r_ramp.span);

    dpe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (product),
        .i_divisor  (r_div),
        .o_quo      (div_quo),
        .o_done     (div_done)
    );

    // level from the quotient; a zero offset skips the divide result
    assign quo = r_zero ? '0 : div_quo;

    always_ff @(posedge i_clk) begin
        if (div_done) begin
            r_level <= r_ramp.up ? (r_ramp.from + quo) : (r_ramp.from - quo);
        end
    end

    // one colour channel per cycle through a shared multiplier
    always_comb begin
        case (i_cmd.chan)
            CH_RED:   chan_in = i_cfg.colour[3*CH_W-1:2*CH_W];
            CH_GREEN: chan_in = i_cfg.colour[2*CH_W-1:CH_W];
            CH_BLUE:  chan_in = i_cfg.colour[CH_W-1:0];
            default:  chan_in = '0;
        endcase
        level_inc = {1'b0, r_level} + 1'b1;
        scaled    = (2*CH_W+1)'(chan_in) * (2*CH_W+1)'(level_inc);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scale) begin
            case (i_cmd.chan)
                CH_RED:   r_red   <= scaled[2*CH_W-1:CH_W];
                CH_GREEN: r_green <= scaled[2*CH_W-1:CH_W];
                CH_BLUE:  r_blue  <= scaled[2*CH_W-1:CH_W];
                default:  ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.write) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_out_data <= r_done ? '0 : {r_level, r_blue, r_green, r_red};
            r_out_user <= r_done ? USER_DONE : USER_FRAME;
        end
    end

    assign o_sts.finish   = r_done;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;

`ifndef SYNTHESIS
    // a stopped effect keeps no stale count or start time
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (r_cycles == '0) && (r_begin == '0))
        else $error("idle envelope holds stale timing state");

    // the ramp offset never reaches the full span
    a_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done && !r_zero |-> (div_quo == '0) || (div_quo < r_ramp.span))
        else $error("ramp quotient out of range");

    // a finished run reports done with blank colour
    a_done_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write && r_done |=> (o_out_user == USER_DONE) && (o_out_data == '0))
        else $error("finish beat carries colour");
`endif

endmodule

// File: design/dpe_ctrl.sv
// ----------------------------------------------------------------------------
// dpe_ctrl
// Sequencer: accepts a tick, runs phase evaluation, the divide and the three
// channel scales (none on a finishing tick), then writes the output register.
// ----------------------------------------------------------------------------
module dpe_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output dpe_pkg::t_cmd o_cmd,
    input  dpe_pkg::t_sts i_sts
);
    import dpe_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EVAL  = 6'b000010,
        S_MUL   = 6'b000100,
        S_DIV   = 6'b001000,
        S_SCALE = 6'b010000,
        S_WRITE = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_chan  r_chan;
    t_chan  n_chan;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_chan  = r_chan;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                if (i_sts.finish) begin
                    n_state = S_WRITE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_chan  = CH_RED;
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                o_cmd.chan  = r_chan;
                if (r_chan == CH_BLUE) begin
                    n_state = S_WRITE;
                end else begin
                    n_chan = r_chan + 1'b1;
                end
            end
            S_WRITE: begin
                if (i_sts.out_free) begin
                    o_cmd.write = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_chan  <= CH_RED;
        end else begin
            r_state <= n_state;
            r_chan  <= n_chan;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

`ifndef SYNTHESIS
    // scaling only walks the three real channels
    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCALE) |-> (r_chan == CH_RED) || (r_chan == CH_GREEN)
            || (r_chan == CH_BLUE))
        else $error("scale channel out of range");

    // divide completion starts scaling at red
    a_div_to_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) && i_sts.div_done |=> (r_state == S_SCALE) && (r_chan == CH_RED))
        else $error("divide done did not start scaling");
`endif

endmodule

// File: design/double_pulse_led_envelope.sv
// ----------------------------------------------------------------------------
// double_pulse_led_envelope
// Double-pulse brightness envelope driven by millisecond frame ticks.
// ----------------------------------------------------------------------------
// Each input beat is a frame tick carrying the millisecond time; each tick
// gives exactly one output beat. The envelope walks rise one, fall one, gap
// one, rise two, fall two and gap two, with durations from the registers,
// repeats cycle_total times, then returns a beat with effect_done set and
// blank colour and rearms for the next tick. A colour tick runs through
// evaluation, the 24-step serial divider and the three channel scales
// through one shared multiplier before it reaches the output register; a
// finishing tick goes from evaluation straight to the write. The next
// tick can be taken in the cycle after the write, and the write waits
// while the previous result is still held in the output register.
// One tick is worked on at a time, while the previous result may still wait
// in the output register.
// Configuration writes are taken every cycle and should be made while idle.
// ----------------------------------------------------------------------------
module double_pulse_led_envelope (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // tick in
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [dpe_pkg::TIME_W-1:0]         s_axis_tdata,   // now_ms
    // result out
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [4*dpe_pkg::CH_W-1:0]         m_axis_tdata,   // red_out, green_out,
                                                               // blue_out, level_out
    output logic [dpe_pkg::USER_W-1:0]         m_axis_tuser,   // frame_update, effect_done
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dpe_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dpe_pkg::COLOUR_W-1:0]       i_cfg_data
);
    import dpe_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dur[PH_RISE_ONE] <= RST_RISE_ONE;
            r_cfg.dur[PH_FALL_ONE] <= RST_FALL_ONE;
            r_cfg.dur[PH_GAP_ONE]  <= RST_GAP_ONE;
            r_cfg.dur[PH_RISE_TWO] <= RST_RISE_TWO;
            r_cfg.dur[PH_FALL_TWO] <= RST_FALL_TWO;
            r_cfg.dur[PH_GAP_TWO]  <= RST_GAP_TWO;
            r_cfg.colour           <= RST_COLOUR;
            r_cfg.total            <= RST_TOTAL;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index)) inside
                CFG_RISE_ONE, CFG_FALL_ONE, CFG_GAP_ONE,
                CFG_RISE_TWO, CFG_FALL_TWO, CFG_GAP_TWO: begin
                    r_cfg.dur[i_cfg_index] <= i_cfg_data[DUR_W-1:0];
                end
                CFG_COLOUR: begin
                    r_cfg.colour <= i_cfg_data;
                end
                CFG_TOTAL: begin
                    r_cfg.total <= i_cfg_data[CNT_W-1:0];
                end
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    dpe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    dpe_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_now       (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );

endmodule
